FILE: sv/assert_macros.svh
// Assertion macros shared by the checker modules.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define CHK_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define CHK_NEVER(lbl, clk, rst, expr, msg) \
  `CHK_PROP(lbl, clk, rst, !(expr), msg)

`endif

FILE: sv/pfds_pkg.sv
// Package for the page frame buffer display streamer: sizes, command codes,
// item types and controller states. Depends on nothing.
`timescale 1ns / 1ps

package pfds_pkg;

  localparam int PANEL_COLUMNS = 128;
  localparam int PANEL_PAGES   = 8;
  localparam int PANEL_ROWS    = PANEL_PAGES * 8;
  localparam int STORE_BYTES   = PANEL_COLUMNS * PANEL_PAGES;
  localparam int ADDR_W        = $clog2(STORE_BYTES);
  localparam int PAGE_W        = (PANEL_PAGES > 1) ? $clog2(PANEL_PAGES) : 1;
  localparam int HEADER_STEPS  = 3;
  localparam int STEP_W        = $clog2(PANEL_COLUMNS + HEADER_STEPS);

  localparam logic [7:0] CMD_PAGE_BASE       = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH        = 8'h10;
  localparam logic [6:0] COLUMN_OFFSET_RESET = 7'h02;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_CLEAR = 2'd1,
    OP_FLUSH = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW,
    S_READ
  } fb_state_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic        pixel_on;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_data;
    logic        frame_last;
  } out_item_t;

endpackage

FILE: sv/page_framebuffer_display_streamer_core.sv
// Flush items and on-panel pixel writes pass through S_READ or S_RMW; other items but clears
// stay in S_IDLE. A flush result enters the output register from S_READ; the input is stalled
// while a result waits there. Pixel writes read, modify and write back one byte.
// A clear sweeps the store one byte a cycle, all STORE_BYTES (1024) bytes, with the input stalled.
// Reset (synchronous) starts the same clearing pass and sets the column offset to 2 and the
// flush position to page 0, step 0.
`timescale 1ns / 1ps

module page_framebuffer_display_streamer_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  pfds_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output pfds_pkg::out_item_t result,
  input  logic                cfg_wen,
  input  logic [6:0]          cfg_wdata
);

  pfds_pkg::fb_state_t state, state_next;

  logic [7:0] mem [pfds_pkg::STORE_BYTES];
  logic [7:0] rd_data;
  logic [pfds_pkg::ADDR_W-1:0] rd_addr;
  logic [pfds_pkg::ADDR_W-1:0] mem_waddr;
  logic [7:0] mem_wdata;
  logic mem_we;

  logic [pfds_pkg::ADDR_W-1:0] clr_addr;
  logic [pfds_pkg::PAGE_W-1:0] flush_page;
  logic [pfds_pkg::STEP_W-1:0] flush_step;
  logic [6:0] column_offset;

  logic [pfds_pkg::ADDR_W-1:0] pend_addr;
  logic [7:0] pend_mask;
  logic pend_on;
  logic [7:0] pend_byte;
  logic pend_data;
  logic pend_last;

  logic accept;
  logic pixel_hit;
  logic [pfds_pkg::ADDR_W-1:0] pix_addr;
  logic [pfds_pkg::ADDR_W-1:0] flush_addr;
  logic [pfds_pkg::STEP_W-1:0] flush_col;
  logic [7:0] head_byte;
  logic head_data;
  logic head_last;
  logic step_wrap;

  assign item_stall = (state != pfds_pkg::S_IDLE) || (result_valid && result_stall);
  assign accept     = item_valid && !item_stall;

  assign pixel_hit = ({1'b0, item.pos_x} < 9'(pfds_pkg::PANEL_COLUMNS)) &&
                     ({1'b0, item.pos_y} < 9'(pfds_pkg::PANEL_ROWS));
  assign pix_addr  = pfds_pkg::ADDR_W'(item.pos_y[7:3]) *
                     pfds_pkg::ADDR_W'(pfds_pkg::PANEL_COLUMNS) +
                     pfds_pkg::ADDR_W'(item.pos_x);
  assign flush_col  = flush_step - pfds_pkg::STEP_W'(pfds_pkg::HEADER_STEPS);
  assign flush_addr = pfds_pkg::ADDR_W'(flush_page) *
                      pfds_pkg::ADDR_W'(pfds_pkg::PANEL_COLUMNS) +
                      pfds_pkg::ADDR_W'(flush_col);
  assign rd_addr    = (item.opcode == pfds_pkg::OP_FLUSH) ? flush_addr : pix_addr;
  assign step_wrap  = flush_step ==
                      pfds_pkg::STEP_W'(pfds_pkg::PANEL_COLUMNS + pfds_pkg::HEADER_STEPS - 1);

  always_comb begin
    head_data = 1'b0;
    head_last = 1'b0;
    case (flush_step)
      pfds_pkg::STEP_W'(0): head_byte = pfds_pkg::CMD_PAGE_BASE + 8'(flush_page);
      pfds_pkg::STEP_W'(1): head_byte = {4'b0000, column_offset[3:0]};
      pfds_pkg::STEP_W'(2): head_byte = pfds_pkg::CMD_COL_HIGH | {5'b00000, column_offset[6:4]};
      default: begin
        head_byte = 8'h00;
        head_data = 1'b1;
        head_last = (flush_col == pfds_pkg::STEP_W'(pfds_pkg::PANEL_COLUMNS - 1)) &&
                    (flush_page == pfds_pkg::PAGE_W'(pfds_pkg::PANEL_PAGES - 1));
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      pfds_pkg::S_CLEAR: begin
        if (clr_addr == pfds_pkg::ADDR_W'(pfds_pkg::STORE_BYTES - 1)) begin
          state_next = pfds_pkg::S_IDLE;
        end
      end
      pfds_pkg::S_IDLE: begin
        if (accept) begin
          case (item.opcode)
            pfds_pkg::OP_PIXEL: if (pixel_hit) state_next = pfds_pkg::S_RMW;
            pfds_pkg::OP_CLEAR: state_next = pfds_pkg::S_CLEAR;
            pfds_pkg::OP_FLUSH: state_next = pfds_pkg::S_READ;
            default:            state_next = pfds_pkg::S_IDLE;
          endcase
        end
      end
      pfds_pkg::S_RMW:  state_next = pfds_pkg::S_IDLE;
      pfds_pkg::S_READ: state_next = pfds_pkg::S_IDLE;
      default:          state_next = pfds_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = pend_on ? (rd_data | pend_mask) : (rd_data & ~pend_mask);
    case (state)
      pfds_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = 8'h00;
      end
      pfds_pkg::S_RMW: mem_we = 1'b1;
      default:         mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pfds_pkg::S_CLEAR;
      clr_addr      <= '0;
      flush_page    <= '0;
      flush_step    <= '0;
      column_offset <= pfds_pkg::COLUMN_OFFSET_RESET;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == pfds_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end else begin
        clr_addr <= '0;
      end
      if (cfg_wen) begin
        column_offset <= cfg_wdata;
      end
      if (accept && item.opcode == pfds_pkg::OP_FLUSH) begin
        if (step_wrap) begin
          flush_step <= '0;
          if (flush_page == pfds_pkg::PAGE_W'(pfds_pkg::PANEL_PAGES - 1)) begin
            flush_page <= '0;
          end else begin
            flush_page <= flush_page + 1'b1;
          end
        end else begin
          flush_step <= flush_step + 1'b1;
        end
      end
      if (state == pfds_pkg::S_READ) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_addr <= rd_addr;
      pend_mask <= 8'h01 << item.pos_y[2:0];
      pend_on   <= item.pixel_on;
      pend_byte <= head_byte;
      pend_data <= head_data;
      pend_last <= head_last;
    end
    if (state == pfds_pkg::S_READ) begin
      result.out_byte   <= pend_data ? rd_data : pend_byte;
      result.is_data    <= pend_data;
      result.frame_last <= pend_last;
    end
  end

endmodule

FILE: sv/pfds_checker.sv
// Port-level checker for the page frame buffer display streamer, bound to its top level.
// Depends on pfds_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pfds_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_stall,
  input pfds_pkg::in_item_t  item,
  input logic                result_valid,
  input logic                result_stall,
  input pfds_pkg::out_item_t result
);

  logic flush_taken;
  logic clear_taken;
  logic result_held;
  logic last_on_cmd;

  assign flush_taken = item_valid && !item_stall && item.opcode == pfds_pkg::OP_FLUSH;
  assign clear_taken = item_valid && !item_stall && item.opcode == pfds_pkg::OP_CLEAR;
  assign result_held = result_valid && result_stall;
  assign last_on_cmd = result_valid && result.frame_last && !result.is_data;

  `CHK_PROP(a_hold, clk, rst, result_held |=> result_valid && $stable(result), "result changed")
  `CHK_NEVER(a_last_is_data, clk, rst, last_on_cmd, "frame end on a command byte")
  `CHK_PROP(a_flush_result, clk, rst, flush_taken |-> ##2 result_valid, "no flush result")
  `CHK_PROP(a_clear_busy, clk, rst, clear_taken |=> item_stall, "input taken during clear")

endmodule

bind page_framebuffer_display_streamer_core pfds_checker u_pfds_checker (.*);

FILE: dv/tb_page_framebuffer_display_streamer_core.sv
// Self-checking testbench for page_framebuffer_display_streamer_core: a scoreboard class
// predicts every flush byte from pixel writes, clears and the column offset register.
// Depends on pfds_pkg and the core module.
`timescale 1ns / 1ps

module tb_page_framebuffer_display_streamer_core;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int FRAME_FLUSHES =
      pfds_pkg::PANEL_PAGES * (pfds_pkg::HEADER_STEPS + pfds_pkg::PANEL_COLUMNS);
  localparam int RANDOM_ITEMS = 1150;
  localparam int PHASE_ITEMS = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 600000;

  class panel_stream_board;
    logic [7:0]          frame_bytes [pfds_pkg::STORE_BYTES];
    int unsigned         stream_page;
    int unsigned         stream_step;
    logic [6:0]          column_offset;
    pfds_pkg::out_item_t bytes_due [$];
    int unsigned         flushes_taken;
    int unsigned         errors;

    function new();
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
      stream_page = 0;
      stream_step = 0;
      column_offset = pfds_pkg::COLUMN_OFFSET_RESET;
      flushes_taken = 0;
      errors = 0;
    endfunction

    function void set_offset(logic [6:0] value);
      column_offset = value;
    endfunction

    function int unsigned pending();
      return bytes_due.size();
    endfunction

    function void note_item(pfds_pkg::in_item_t it);
      pfds_pkg::out_item_t want;
      int unsigned         idx;
      int unsigned         col;
      case (it.opcode)
        pfds_pkg::OP_PIXEL: begin
          if (it.pos_x < pfds_pkg::PANEL_COLUMNS && it.pos_y < pfds_pkg::PANEL_ROWS) begin
            idx = it.pos_x + (it.pos_y >> 3) * pfds_pkg::PANEL_COLUMNS;
            frame_bytes[idx][it.pos_y[2:0]] = it.pixel_on;
          end
        end
        pfds_pkg::OP_CLEAR: begin
          foreach (frame_bytes[i]) frame_bytes[i] = '0;
        end
        pfds_pkg::OP_FLUSH: begin
          want.is_data = 1'b0;
          want.frame_last = 1'b0;
          if (stream_step == 0) begin
            want.out_byte = pfds_pkg::CMD_PAGE_BASE + 8'(stream_page);
          end else if (stream_step == 1) begin
            want.out_byte = {4'h0, column_offset[3:0]};
          end else if (stream_step == 2) begin
            want.out_byte = pfds_pkg::CMD_COL_HIGH | {5'b0, column_offset[6:4]};
          end else begin
            col = stream_step - pfds_pkg::HEADER_STEPS;
            want.out_byte = frame_bytes[stream_page * pfds_pkg::PANEL_COLUMNS + col];
            want.is_data = 1'b1;
            want.frame_last = (col == pfds_pkg::PANEL_COLUMNS - 1) &&
                              (stream_page == pfds_pkg::PANEL_PAGES - 1);
          end
          bytes_due.push_back(want);
          flushes_taken++;
          stream_step++;
          if (stream_step >= pfds_pkg::HEADER_STEPS + pfds_pkg::PANEL_COLUMNS) begin
            stream_step = 0;
            stream_page = (stream_page + 1) % pfds_pkg::PANEL_PAGES;
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(pfds_pkg::out_item_t got);
      pfds_pkg::out_item_t want;
      if (bytes_due.size() == 0) begin
        $error("unexpected result: out_byte %02h is_data %0b frame_last %0b",
               got.out_byte, got.is_data, got.frame_last);
        errors++;
        return;
      end
      want = bytes_due.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.is_data !== want.is_data) begin
        $error("is_data: expected %0b, got %0b", want.is_data, got.is_data);
        errors++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_last: expected %0b, got %0b", want.frame_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  pfds_pkg::in_item_t  item = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  pfds_pkg::out_item_t result;
  logic                cfg_wen = 1'b0;
  logic [6:0]          cfg_wdata = '0;

  panel_stream_board board = new();

  int unsigned burst_left = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_tick = 0;
  int unsigned cycle_count = 0;

  page_framebuffer_display_streamer_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic offer_item(pfds_pkg::opcode_t op, logic [7:0] x, logic [7:0] y, logic on);
    pfds_pkg::in_item_t it;
    int unsigned        gap;
    it.opcode = op;
    it.pos_x = x;
    it.pos_y = y;
    it.pixel_on = on;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    board.note_item(it);
  endtask

  // The block may still be sweeping a clear when the last flush byte arrives,
  // so the register is only written after a full store sweep has had time to end.
  task automatic write_offset(logic [6:0] value);
    item_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (pfds_pkg::STORE_BYTES + 16) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    board.set_offset(value);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        board.check_result(result);
        results_seen++;
        if (results_seen == 150 || results_seen == 700) hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      stall_tick++;
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 9) < 3);
          2: result_stall <= (stall_tick % 3 == 0);
          default: result_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned       counted;
    int unsigned       in_phase;
    int unsigned       phase;
    int unsigned       r;
    pfds_pkg::opcode_t op;
    logic [7:0]        x;
    logic [7:0]        y;
    logic              on;
    logic [6:0]        offset;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Panel corners, writes just off the panel, the unused opcode, and
    // pixel writes and a clear landing in the middle of a page stream.
    offer_item(pfds_pkg::OP_PIXEL, 8'd0, 8'd0, 1'b1);
    offer_item(pfds_pkg::OP_PIXEL, 8'd127, 8'd63, 1'b1);
    offer_item(pfds_pkg::OP_PIXEL, 8'd128, 8'd0, 1'b1);
    offer_item(pfds_pkg::OP_PIXEL, 8'd0, 8'd64, 1'b1);
    offer_item(pfds_pkg::OP_PIXEL, 8'd255, 8'd255, 1'b1);
    offer_item(pfds_pkg::OP_PIXEL, 8'd5, 8'd3, 1'b1);
    offer_item(pfds_pkg::OP_PIXEL, 8'd5, 8'd3, 1'b0);
    offer_item(pfds_pkg::OP_PIXEL, 8'd1, 8'd7, 1'b1);
    offer_item(pfds_pkg::opcode_t'(OP_UNUSED), 8'd255, 8'd255, 1'b1);
    repeat (5) offer_item(pfds_pkg::OP_FLUSH, 8'd0, 8'd0, 1'b0);
    offer_item(pfds_pkg::OP_PIXEL, 8'd2, 8'd0, 1'b1);
    offer_item(pfds_pkg::OP_FLUSH, 8'd255, 8'd255, 1'b1);
    offer_item(pfds_pkg::OP_CLEAR, 8'd0, 8'd0, 1'b0);
    offer_item(pfds_pkg::OP_FLUSH, 8'd0, 8'd0, 1'b0);
    offer_item(pfds_pkg::OP_PIXEL, 8'd4, 8'd1, 1'b1);
    offer_item(pfds_pkg::OP_FLUSH, 8'd0, 8'd0, 1'b0);
    offer_item(pfds_pkg::OP_PIXEL, 8'd127, 8'd63, 1'b1);

    counted = 0;
    in_phase = 0;
    phase = 0;
    while (counted < RANDOM_ITEMS || board.flushes_taken < FRAME_FLUSHES + 40) begin
      if (in_phase == PHASE_ITEMS) begin
        if (phase == 0) offset = 7'd127;
        else if (phase == 1) offset = 7'd0;
        else offset = 7'($urandom_range(0, 127));
        write_offset(offset);
        phase++;
        in_phase = 0;
      end
      x = 8'($urandom_range(0, 255));
      y = 8'($urandom_range(0, 255));
      on = ($urandom_range(0, 9) < 6);
      r = $urandom_range(0, 99);
      if (r < 90) begin
        op = pfds_pkg::OP_FLUSH;
      end else if (r < 97) begin
        op = pfds_pkg::OP_PIXEL;
        r = $urandom_range(0, 99);
        if (r < 70) begin
          x = 8'($urandom_range(0, pfds_pkg::PANEL_COLUMNS - 1));
          y = 8'(board.stream_page * 8 + $urandom_range(0, 7));
        end else if (r < 85) begin
          x = 8'($urandom_range(0, pfds_pkg::PANEL_COLUMNS - 1));
          y = 8'($urandom_range(0, pfds_pkg::PANEL_ROWS - 1));
        end
      end else if (r < 99) begin
        op = pfds_pkg::opcode_t'(OP_UNUSED);
      end else begin
        op = pfds_pkg::OP_CLEAR;
      end
      offer_item(op, x, y, on);
      if (!(op == pfds_pkg::opcode_t'(OP_UNUSED) ||
            (op == pfds_pkg::OP_PIXEL &&
             (x >= pfds_pkg::PANEL_COLUMNS || y >= pfds_pkg::PANEL_ROWS))))
        counted++;
      in_phase++;
    end

    item_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
